/* src/lafk_pkg.sv */
package lafk_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int FRAC_BITS     = 13;

	// Angle / CORDIC datapath width (Q30 radians, guard for +-2*pi sums)
	localparam int AW = 36;

	localparam int TABLE_LEN = 24;
	localparam logic signed [AW-1:0] PI_Q30      = 36'sd3373259426;
	localparam logic signed [AW-1:0] HALF_PI_Q30 = 36'sd1686629713;
	localparam logic signed [AW-1:0] TWO_PI_Q30  = 36'sd6746518852;
	localparam logic signed [AW-1:0] GAIN_Q30    = 36'sd652032874;

	localparam logic [13:0] UPPER_RST = 14'd5014;
	localparam logic [13:0] LOWER_RST = 14'd4686;
	localparam logic [13:0] BASE_RST  = 14'd4235;

	// Register indexes
	localparam logic [1:0] REG_UPPER = 2'd0;
	localparam logic [1:0] REG_LOWER = 2'd1;
	localparam logic [1:0] REG_BASE  = 2'd2;

	function automatic logic signed [AW-1:0] atan_q30(input int i);
		logic signed [AW-1:0] t;
		begin
			unique case (i)
				0: t = 36'sd843314857;
				1: t = 36'sd497837829;
				2: t = 36'sd263043837;
				3: t = 36'sd133525159;
				4: t = 36'sd67021687;
				5: t = 36'sd33543516;
				6: t = 36'sd16775851;
				7: t = 36'sd8388437;
				8: t = 36'sd4194283;
				9: t = 36'sd2097149;
				10: t = 36'sd1048576;
				11: t = 36'sd524288;
				12: t = 36'sd262144;
				13: t = 36'sd131072;
				14: t = 36'sd65536;
				15: t = 36'sd32768;
				16: t = 36'sd16384;
				17: t = 36'sd8192;
				18: t = 36'sd4096;
				19: t = 36'sd2048;
				20: t = 36'sd1024;
				21: t = 36'sd512;
				22: t = 36'sd256;
				default: t = 36'sd128;
			endcase
			return t;
		end
	endfunction

	// One CORDIC micro-rotation lane state
	typedef struct packed {
		logic signed [AW-1:0] x;
		logic signed [AW-1:0] y;
		logic signed [AW-1:0] z;
		logic                 flip;
	} rot_t;

endpackage

/* src/lafk_cell.sv */
// One CORDIC stage: rotates three angle lanes by atan(2^-IDX).
module lafk_cell #(
	parameter int IDX = 0
) (
	input  logic                 clk,
	input  lafk_pkg::rot_t [2:0] rot_i,
	output lafk_pkg::rot_t [2:0] rot_o
);
	localparam logic signed [lafk_pkg::AW-1:0] ATAN = lafk_pkg::atan_q30(IDX);

	lafk_pkg::rot_t [2:0] nxt;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			nxt[k].flip = rot_i[k].flip;
			if (!rot_i[k].z[lafk_pkg::AW-1]) begin
				nxt[k].x = rot_i[k].x - (rot_i[k].y >>> IDX);
				nxt[k].y = rot_i[k].y + (rot_i[k].x >>> IDX);
				nxt[k].z = rot_i[k].z - ATAN;
			end else begin
				nxt[k].x = rot_i[k].x + (rot_i[k].y >>> IDX);
				nxt[k].y = rot_i[k].y - (rot_i[k].x >>> IDX);
				nxt[k].z = rot_i[k].z + ATAN;
			end
		end
	end

	always_ff @(posedge clk) begin
		rot_o <= nxt;
	end
endmodule

/* src/lafk_regs.sv */
// APB register file for link lengths and base offset.
module lafk_regs (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic [13:0] upper_q,
	output logic [13:0] lower_q,
	output logic [13:0] base_q
);
	logic [1:0] idx;
	assign idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q <= lafk_pkg::UPPER_RST;
			lower_q <= lafk_pkg::LOWER_RST;
			base_q  <= lafk_pkg::BASE_RST;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				lafk_pkg::REG_UPPER: upper_q <= pwdata[13:0];
				lafk_pkg::REG_LOWER: lower_q <= pwdata[13:0];
				lafk_pkg::REG_BASE:  base_q  <= pwdata[13:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			lafk_pkg::REG_UPPER: prdata = {18'd0, upper_q};
			lafk_pkg::REG_LOWER: prdata = {18'd0, lower_q};
			lafk_pkg::REG_BASE:  prdata = {18'd0, base_q};
			default:             prdata = 32'd0;
		endcase
	end
endmodule

/* src/lift_arm_forward_kinematics.sv */
// Lift-mounted two-link arm forward kinematics. One joint set may be started
// every clock cycle (busy stays low); each result appears on pos_x/pos_y/pos_z/
// saturated with done high for exactly one cycle. Each joint set passes through
// angle reduction, the chain of CORDIC cells (one per stage) and the
// multiply/round stages after it. The receiver cannot stall the block, so every
// result must be taken when done is high. Link lengths and offset sit in APB
// registers; the lengths are sampled when an item enters the multiply stages
// and the offset at stage D; change them only while the block is idle.
module lift_arm_forward_kinematics #(
	parameter int CORDIC_STAGES = lafk_pkg::CORDIC_STAGES,
	parameter int FRAC_BITS     = lafk_pkg::FRAC_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [13:0]        lift_travel,
	input  logic signed [15:0] base_angle,
	input  logic signed [15:0] shoulder_angle,
	input  logic signed [15:0] elbow_angle,
	output logic               done,
	output logic signed [15:0] pos_x,
	output logic signed [15:0] pos_y,
	output logic signed [15:0] pos_z,
	output logic               saturated,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	localparam int AW  = lafk_pkg::AW;
	localparam int NST = (CORDIC_STAGES < lafk_pkg::TABLE_LEN) ?
		CORDIC_STAGES : lafk_pkg::TABLE_LEN;
	localparam int LAT = NST + 8;
	localparam int UP  = 30 - FRAC_BITS;

	logic [13:0] upper_q, lower_q, base_q;

	assign busy   = 1'b0;
	assign pready = 1'b1;

	lafk_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
		.upper_q, .lower_q, .base_q
	);

	// Valid shift line and lift carried alongside the datapath up to stage D
	logic [LAT-1:0] vld_q;
	logic [13:0]    lift_q [LAT-2];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else         vld_q <= {vld_q[LAT-2:0], start};
	end
	always_ff @(posedge clk) begin
		lift_q[0] <= lift_travel;
		for (int k = 1; k < LAT - 2; k++) lift_q[k] <= lift_q[k-1];
	end

	// Stage 1: scale to Q30 and sum shoulder+elbow
	logic signed [AW-1:0] ang_s1 [3];
	always_ff @(posedge clk) begin
		ang_s1[0] <= AW'(base_angle) <<< UP;
		ang_s1[1] <= AW'(shoulder_angle) <<< UP;
		ang_s1[2] <= (AW'(shoulder_angle) + AW'(elbow_angle)) <<< UP;
	end

	// Stage 2: wrap to [-pi,pi); |angle| < 4*pi so at most two corrections
	logic signed [AW-1:0] ang_s2 [3];
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			logic signed [AW-1:0] a;
			a = ang_s1[k];
			if (a >= lafk_pkg::PI_Q30) a = a - lafk_pkg::TWO_PI_Q30;
			else if (a < -lafk_pkg::PI_Q30) a = a + lafk_pkg::TWO_PI_Q30;
			if (a >= lafk_pkg::PI_Q30) a = a - lafk_pkg::TWO_PI_Q30;
			else if (a < -lafk_pkg::PI_Q30) a = a + lafk_pkg::TWO_PI_Q30;
			ang_s2[k] <= a;
		end
	end

	// Stage 3: fold into +-pi/2 and seed the CORDIC
	lafk_pkg::rot_t [2:0] seed_s3;
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			seed_s3[k].x <= lafk_pkg::GAIN_Q30;
			seed_s3[k].y <= '0;
			if (ang_s2[k] > lafk_pkg::HALF_PI_Q30) begin
				seed_s3[k].z <= ang_s2[k] - lafk_pkg::PI_Q30;
				seed_s3[k].flip <= 1'b1;
			end else if (ang_s2[k] < -lafk_pkg::HALF_PI_Q30) begin
				seed_s3[k].z <= ang_s2[k] + lafk_pkg::PI_Q30;
				seed_s3[k].flip <= 1'b1;
			end else begin
				seed_s3[k].z <= ang_s2[k];
				seed_s3[k].flip <= 1'b0;
			end
		end
	end

	// CORDIC cell chain
	lafk_pkg::rot_t [2:0] chain [NST+1];
	assign chain[0] = seed_s3;
	for (genvar g = 0; g < NST; g++) begin : g_cell
		lafk_cell #(.IDX(g)) u_cell (.clk, .rot_i(chain[g]), .rot_o(chain[g+1]));
	end

	// Apply fold sign: cos/sin in Q30 (fit in 32 bits)
	logic signed [31:0] cosv [3], sinv [3];
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			cosv[k] = chain[NST][k].flip ? -32'(chain[NST][k].x) : 32'(chain[NST][k].x);
			sinv[k] = chain[NST][k].flip ? -32'(chain[NST][k].y) : 32'(chain[NST][k].y);
		end
	end

	// Stage A: link products (15x32)
	logic signed [46:0] p1c_a, p2c_a, p1s_a, p2s_a;
	logic signed [31:0] cb_a, sb_a;
	always_ff @(posedge clk) begin
		p1c_a <= $signed({1'b0, upper_q}) * cosv[1];
		p2c_a <= $signed({1'b0, lower_q}) * cosv[2];
		p1s_a <= $signed({1'b0, upper_q}) * sinv[1];
		p2s_a <= $signed({1'b0, lower_q}) * sinv[2];
		cb_a  <= cosv[0];
		sb_a  <= sinv[0];
	end

	// Stage B: sums and rounding
	logic signed [32:0] reach_b;
	logic signed [17:0] height_b;
	logic signed [31:0] cb_b, sb_b;
	logic signed [47:0] rs, hs;
	always_comb begin
		rs = 48'(p1c_a) + 48'(p2c_a) + 48'sd16384;
		hs = 48'(p1s_a) + 48'(p2s_a) + 48'sd536870912;
	end
	always_ff @(posedge clk) begin
		reach_b  <= 33'(rs >>> 15);
		height_b <= 18'(hs >>> 30);
		cb_b     <= cb_a;
		sb_b     <= sb_a;
	end

	// Stage C: base rotation products (33x32)
	logic signed [64:0] px_c, py_c;
	logic signed [17:0] height_c;
	always_ff @(posedge clk) begin
		px_c     <= 65'(reach_b) * 65'(cb_b);
		py_c     <= 65'(reach_b) * 65'(sb_b);
		height_c <= height_b;
	end

	// Stage D: round x,y and form z
	logic signed [20:0] x_d, y_d, z_d;
	logic signed [65:0] xr, yr;
	always_comb begin
		xr = 66'(px_c) + (66'sd1 <<< 44);
		yr = 66'(py_c) + (66'sd1 <<< 44);
	end
	always_ff @(posedge clk) begin
		x_d <= 21'(xr >>> 45);
		y_d <= 21'(yr >>> 45);
		z_d <= 21'(height_c) + 21'(lift_q[LAT-3]) + 21'(base_q);
	end

	// Stage E: saturate and register outputs
	function automatic logic signed [15:0] clip(input logic signed [20:0] v);
		if (v > 21'sd32767)       return 16'sh7fff;
		else if (v < -21'sd32768) return 16'sh8000;
		else                      return v[15:0];
	endfunction
	function automatic logic over(input logic signed [20:0] v);
		return (v > 21'sd32767) || (v < -21'sd32768);
	endfunction

	always_ff @(posedge clk) begin
		pos_x     <= clip(x_d);
		pos_y     <= clip(y_d);
		pos_z     <= clip(z_d);
		saturated <= over(x_d) | over(y_d) | over(z_d);
	end
	assign done = vld_q[LAT-1];
endmodule

/* src/lafk_checker.sv */
// Port-level checks for the forward kinematics block.
module lafk_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               busy,
	input logic               done,
	input logic               pready,
	input logic signed [15:0] pos_x,
	input logic signed [15:0] pos_y,
	input logic signed [15:0] pos_z,
	input logic               saturated
);
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");
	// A result is never unknown
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$isunknown({pos_x, pos_y, pos_z, saturated}))
		else $error("unknown result");
	// A clipped result has at least one coordinate on a rail
	a_sat_rail: assert property (@(posedge clk) disable iff (!arst_n)
		done && saturated |->
		(pos_x == 16'sh7fff) || (pos_x == 16'sh8000) ||
		(pos_y == 16'sh7fff) || (pos_y == 16'sh8000) ||
		(pos_z == 16'sh7fff) || (pos_z == 16'sh8000))
		else $error("sat flag without rail");
endmodule

bind lift_arm_forward_kinematics lafk_checker u_chk (
	.clk, .arst_n, .busy, .done, .pready, .pos_x, .pos_y, .pos_z, .saturated
);

/* verif/tb_top.sv */
// Predicted position of one joint set
typedef struct {
	logic signed [15:0] x;
	logic signed [15:0] y;
	logic signed [15:0] z;
	logic               sat;
} pos_t;

// Scoreboard: holds predicted joint-set positions in arrival order
class kin_scoreboard;
	pos_t pending[$];
	int   errors;
	int   checked;

	function new();
		errors  = 0;
		checked = 0;
	endfunction

	function void note_item(pos_t p);
		pending.insert(pending.size(), p);
	endfunction

	function void check_result(logic signed [15:0] x, logic signed [15:0] y,
			logic signed [15:0] z, logic sat);
		pos_t p;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result x=%0d y=%0d z=%0d sat=%0b",
				$time, x, y, z, sat);
			errors++;
			return;
		end
		p = pending.pop_front();
		checked++;
		if (x !== p.x) begin
			$display("%0t: pos_x expected %0d actual %0d", $time, p.x, x);
			errors++;
		end
		if (y !== p.y) begin
			$display("%0t: pos_y expected %0d actual %0d", $time, p.y, y);
			errors++;
		end
		if (z !== p.z) begin
			$display("%0t: pos_z expected %0d actual %0d", $time, p.z, z);
			errors++;
		end
		if (sat !== p.sat) begin
			$display("%0t: saturated expected %0b actual %0b", $time, p.sat, sat);
			errors++;
		end
	endfunction
endclass

module tb_top;
	localparam int LATENCY = lafk_pkg::CORDIC_STAGES + 8;
	localparam longint PI_V   = 64'sd3373259426;
	localparam longint HPI_V  = 64'sd1686629713;
	localparam longint TPI_V  = 64'sd6746518852;
	localparam longint GAIN_V = 64'sd652032874;
	// Index with no register behind it
	localparam logic [1:0] REG_UNUSED = 2'd3;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [13:0]        lift_travel;
	logic signed [15:0] base_angle;
	logic signed [15:0] shoulder_angle;
	logic signed [15:0] elbow_angle;
	logic               done;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic signed [15:0] pos_z;
	logic               saturated;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [3:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	// Testbench copy of the link registers
	logic [13:0] l1_len;
	logic [13:0] l2_len;
	logic [13:0] z_offset;

	kin_scoreboard sb;
	int            total_items;

	lift_arm_forward_kinematics dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.lift_travel(lift_travel), .base_angle(base_angle),
		.shoulder_angle(shoulder_angle), .elbow_angle(elbow_angle),
		.done(done), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.saturated(saturated), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50000000;
		$display("Test completed with failures");
		$finish;
	end

	// Arithmetic shift of a 64-bit value (floor)
	function automatic longint sra64(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint rnd_shift(longint v, int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	// Reduce a Q30 angle into [-pi, pi)
	function automatic longint reduce_angle(longint v);
		longint r;
		r = v % TPI_V;
		if (r < 0)
			r += TPI_V;
		if (r >= PI_V)
			r -= TPI_V;
		return r;
	endfunction

	function automatic longint atan_entry(int i);
		longint tbl [24] = '{843314857, 497837829, 263043837, 133525159,
			67021687, 33543516, 16775851, 8388437, 4194283, 2097149,
			1048576, 524288, 262144, 131072, 65536, 32768, 16384, 8192,
			4096, 2048, 1024, 512, 256, 128};
		return tbl[i];
	endfunction

	// Rotation-mode CORDIC on a reduced Q30 angle
	task automatic rotate_unit(input longint ang, output longint c, output longint s);
		longint x, y, z, dx, dy;
		bit flip;
		x = GAIN_V;
		y = 0;
		z = ang;
		flip = 0;
		if (z > HPI_V) begin
			z -= PI_V;
			flip = 1;
		end else if (z < -HPI_V) begin
			z += PI_V;
			flip = 1;
		end
		for (int i = 0; i < lafk_pkg::CORDIC_STAGES && i < 24; i++) begin
			dx = sra64(y, i);
			dy = sra64(x, i);
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= atan_entry(i);
			end else begin
				x += dx;
				y -= dy;
				z += atan_entry(i);
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = x;
		s = y;
	endtask

	function automatic longint clip_pos(longint v, ref bit sat);
		if (v > 32767) begin
			sat = 1;
			return 32767;
		end
		if (v < -32768) begin
			sat = 1;
			return -32768;
		end
		return v;
	endfunction

	// Predicted end-effector position of one joint set
	task automatic predict_position(input logic [13:0] lift, input logic signed [15:0] ba,
			input logic signed [15:0] sa, input logic signed [15:0] ea,
			output pos_t p);
		longint up, b, s, e, cb, snb, c1, s1, c12, s12, reach, height, x, y, z;
		bit sat;
		up = 64'sd1 <<< (30 - lafk_pkg::FRAC_BITS);
		b = longint'(ba) * up;
		s = longint'(sa) * up;
		e = longint'(ea) * up;
		sat = 0;
		rotate_unit(reduce_angle(b), cb, snb);
		rotate_unit(reduce_angle(s), c1, s1);
		rotate_unit(reduce_angle(s + e), c12, s12);
		reach = rnd_shift(longint'(l1_len) * c1 + longint'(l2_len) * c12, 15);
		height = rnd_shift(longint'(l1_len) * s1 + longint'(l2_len) * s12, 30);
		x = rnd_shift(reach * cb, 45);
		y = rnd_shift(reach * snb, 45);
		z = longint'(lift) + longint'(z_offset) + height;
		x = clip_pos(x, sat);
		y = clip_pos(y, sat);
		z = clip_pos(z, sat);
		p.x = x[15:0];
		p.y = y[15:0];
		p.z = z[15:0];
		p.sat = sat;
	endtask

	// Result monitor: done is a one-cycle strobe
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(pos_x, pos_y, pos_z, saturated);
	end

	// APB write: setup then access cycle
	task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			lafk_pkg::REG_UPPER: l1_len = val[13:0];
			lafk_pkg::REG_LOWER: l2_len = val[13:0];
			lafk_pkg::REG_BASE:  z_offset = val[13:0];
			default: ;
		endcase
	endtask

	// Drive one joint set; prediction is noted at the accepting edge
	task automatic send_joints(input logic [13:0] lift, input logic signed [15:0] ba,
			input logic signed [15:0] sa, input logic signed [15:0] ea);
		pos_t p;
		start          <= 1'b1;
		lift_travel    <= lift;
		base_angle     <= ba;
		shoulder_angle <= sa;
		elbow_angle    <= ea;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict_position(lift, ba, sa, ea, p);
		sb.note_item(p);
		total_items++;
	endtask

	task automatic idle_cycles(input int n);
		start <= 1'b0;
		repeat (n)
			@(posedge clk);
	endtask

	task automatic drain();
		int guard;
		start <= 1'b0;
		guard = 0;
		while (sb.pending.size() != 0 && guard < 10000) begin
			@(posedge clk);
			guard++;
		end
		repeat (LATENCY + 4)
			@(posedge clk);
	endtask

	function automatic logic signed [15:0] rand_angle();
		case ($urandom_range(0, 5))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'($urandom_range(0, 25736) - 12868);
			default: return 16'($urandom());
		endcase
	endfunction

	// Random joint sets in bursts with gaps
	task automatic random_phase(input int n);
		int sent, burst;
		logic [13:0] lift;
		sent = 0;
		while (sent < n) begin
			burst = $urandom_range(1, 40);
			for (int k = 0; k < burst && sent < n; k++) begin
				lift = ($urandom_range(0, 9) == 0) ? 14'($urandom()) : 14'($urandom_range(0, 8192));
				send_joints(lift, rand_angle(), rand_angle(), rand_angle());
				sent++;
			end
			if ($urandom_range(0, 3) != 0)
				idle_cycles($urandom_range(1, 12));
		end
	endtask

	initial begin
		sb = new();
		total_items = 0;
		l1_len = lafk_pkg::UPPER_RST;
		l2_len = lafk_pkg::LOWER_RST;
		z_offset = lafk_pkg::BASE_RST;
		arst_n = 1'b0;
		start = 1'b0;
		lift_travel = '0;
		base_angle = '0;
		shoulder_angle = '0;
		elbow_angle = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset lengths, field extremes, lift beyond range
		send_joints(14'd0, 16'sd0, 16'sd0, 16'sd0);
		send_joints(14'd8192, 16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_joints(14'h3fff, 16'sh8000, 16'sh8000, 16'sh8000);
		send_joints(14'd4096, 16'sd12868, 16'sd12868, -16'sd12868);
		send_joints(14'd100, -16'sd12868, 16'sd25736, 16'sd0);
		send_joints(14'd0, 16'sd6434, -16'sd12868, 16'sd12868);
		send_joints(14'd8192, 16'sd25735, 16'sd12868, 16'sd0);
		idle_cycles(3);
		send_joints(14'h2aaa, 16'sh5555, 16'shaaaa, 16'sh5555);
		send_joints(14'h1555, 16'shaaaa, 16'sh5555, 16'shaaaa);
		drain();

		// Max lengths: clipping; also a wide value and an unknown index
		reg_write(lafk_pkg::REG_UPPER, 32'hffff_ffff);
		reg_write(lafk_pkg::REG_LOWER, 32'h0000_3fff);
		reg_write(lafk_pkg::REG_BASE, 32'hffff_3fff);
		reg_write(REG_UNUSED, 32'h0000_1234);
		send_joints(14'h3fff, 16'sd0, 16'sd12868, 16'sd0);
		send_joints(14'd0, 16'sd0, 16'sd0, 16'sd0);
		send_joints(14'd0, 16'sd12868, 16'sd0, 16'sd0);
		send_joints(14'd0, -16'sd25736, 16'sd0, 16'sd0);
		send_joints(14'd0, 16'sd0, -16'sd12868, 16'sd0);
		send_joints(14'd0, 16'sd3217, 16'sd3217, 16'sd0);
		random_phase(400);
		drain();

		// Zero lengths
		reg_write(lafk_pkg::REG_UPPER, 32'd0);
		reg_write(lafk_pkg::REG_LOWER, 32'd0);
		reg_write(lafk_pkg::REG_BASE, 32'd0);
		send_joints(14'd0, 16'sd0, 16'sd0, 16'sd0);
		random_phase(300);
		drain();

		// Reset-like lengths, then random lengths
		reg_write(lafk_pkg::REG_UPPER, 32'(lafk_pkg::UPPER_RST));
		reg_write(lafk_pkg::REG_LOWER, 32'(lafk_pkg::LOWER_RST));
		reg_write(lafk_pkg::REG_BASE, 32'(lafk_pkg::BASE_RST));
		random_phase(500);
		drain();
		for (int ph = 0; ph < 3; ph++) begin
			reg_write(lafk_pkg::REG_UPPER, $urandom());
			reg_write(lafk_pkg::REG_LOWER, $urandom());
			reg_write(lafk_pkg::REG_BASE, $urandom());
			random_phase(180);
			drain();
		end

		$display("Covered %0d joint sets over six register settings, %0d results checked.",
			total_items, sb.checked);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

/* files.f */
src/lafk_pkg.sv
src/lafk_cell.sv
src/lafk_regs.sv
src/lift_arm_forward_kinematics.sv
src/lafk_checker.sv
verif/tb_top.sv
